[rtl/assert_macros.svh]
// shared assertion macros, empty in synthesis builds
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expression holds on every clock edge out of reset
`define ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, expr)
`define ASSERT_IMPLIES(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)

`endif

`endif

[rtl/vp9d_pkg.sv]
`default_nettype none

package vp9d_pkg;

    // parser phases within one packet
    typedef enum logic [3:0] {
        PH_DESC  = 4'd0,
        PH_PID1  = 4'd1,
        PH_PID2  = 4'd2,
        PH_LAYER = 4'd3,
        PH_REF   = 4'd4,
        PH_REFX  = 4'd5,
        PH_SS    = 4'd6,
        PH_SSY   = 4'd7,
        PH_SSG   = 4'd8,
        PH_GROUP = 4'd9,
        PH_PDIFF = 4'd10,
        PH_PAY0  = 4'd11,
        PH_PAY   = 4'd12,
        PH_SKIP  = 4'd13
    } phase_t;

    // result kinds
    typedef enum logic [2:0] {
        KIND_PAYLOAD   = 3'd0,
        KIND_DISCARD   = 3'd1,
        KIND_SHORT     = 3'd2,
        KIND_MARKER    = 3'd3,
        KIND_LAYERS    = 3'd4,
        KIND_IGNORED   = 3'd5
    } kind_t;

    // descriptor bit positions (bit 0 reused for the ss g flag)
    localparam int FLAG_I = 7;
    localparam int FLAG_L = 5;
    localparam int FLAG_F = 4;
    localparam int FLAG_B = 3;
    localparam int FLAG_E = 2;
    localparam int FLAG_V = 1;
    localparam int FLAG_G = 0;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        packet_first;
        logic        packet_last;
        logic        marker;
        logic [31:0] rtp_timestamp;
    } byte_item_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  payload_byte;
        logic        frame_first;
        logic        frame_last;
        logic [31:0] frame_stamp;
        logic        run_last;
    } result_t;

    // results produced by one parse step
    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } push_t;

    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_DEPTH = 1 << FIFO_PTR_W;

    typedef logic [FIFO_PTR_W-1:0] fifo_ptr_t;
    typedef logic [FIFO_PTR_W:0]   fifo_cnt_t;

    localparam fifo_cnt_t FIFO_ROOM_MAX = fifo_cnt_t'(FIFO_DEPTH - 2);
    localparam fifo_cnt_t FIFO_FULL     = fifo_cnt_t'(FIFO_DEPTH);

endpackage

`default_nettype wire

[rtl/vp9d_byte_if.sv]
`default_nettype none

interface vp9d_byte_if;
    import vp9d_pkg::*;

    logic       valid;
    logic       ready;
    byte_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[rtl/vp9d_result_if.sv]
`default_nettype none

interface vp9d_result_if;
    import vp9d_pkg::*;

    logic    valid;
    logic    ready;
    result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[rtl/vp9d_parser.sv]
`default_nettype none

`include "assert_macros.svh"

module vp9d_parser (
    input  wire logic           clk,
    input  wire logic           rst_n,
    vp9d_byte_if.sink           pkt,
    input  wire logic           room,
    output vp9d_pkg::push_t     push
);
    import vp9d_pkg::*;

    byte_item_t  item_reg;
    logic        item_valid_reg;
    logic        item_valid_next;
    logic        fire;

    phase_t      phase_reg, phase_next;
    logic [7:0]  flags_reg, flags_next;
    logic [1:0]  ref_reg, ref_next;
    logic [7:0]  group_reg, group_next;
    logic [2:0]  inner_reg, inner_next;
    logic        open_reg, open_next;
    logic [31:0] stamp_reg, stamp_next;
    logic        fresh_reg, fresh_next;

    logic        disc;
    logic        main_v;
    logic        hdr;
    result_t     disc_res;
    result_t     main_res;

    // next header section that is present
    function automatic phase_t next_from(input logic [2:0] level, input logic [7:0] flags,
                                         input logic [1:0] refs);
        phase_t ph;
        if (level < 3'd1 && flags[FLAG_I])
            ph = PH_PID1;
        else if (level < 3'd2 && flags[FLAG_L])
            ph = PH_LAYER;
        else if (level < 3'd3 && refs != 2'd0)
            ph = PH_REF;
        else if (level < 3'd4 && flags[FLAG_V])
            ph = PH_SS;
        else
            ph = PH_PAY0;
        return ph;
    endfunction

    function automatic phase_t after_ssy(input logic [7:0] flags);
        return flags[FLAG_G] ? PH_SSG : PH_PAY0;
    endfunction

    assign fire      = item_valid_reg && room;
    assign pkt.ready = !item_valid_reg || room;

    always_comb
    begin
        if (pkt.valid && pkt.ready)
            item_valid_next = 1'b1;
        else if (fire)
            item_valid_next = 1'b0;
        else
            item_valid_next = item_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else
            item_valid_reg <= item_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pkt.valid && pkt.ready)
            item_reg <= pkt.payload;
    end

    // one parse step on the registered byte
    always_comb
    begin
        phase_next = phase_reg;
        flags_next = flags_reg;
        ref_next   = ref_reg;
        group_next = group_reg;
        inner_next = inner_reg;
        open_next  = open_reg;
        stamp_next = stamp_reg;
        fresh_next = fresh_reg;
        disc       = 1'b0;
        main_v     = 1'b0;
        hdr        = 1'b1;

        main_res              = '0;
        main_res.kind         = KIND_SHORT;
        main_res.frame_stamp  = item_reg.rtp_timestamp;
        main_res.run_last     = 1'b1;

        if (item_reg.packet_first || phase_reg == PH_DESC)
        begin
            if (open_reg && stamp_reg != item_reg.rtp_timestamp)
            begin
                disc       = 1'b1;
                open_next  = 1'b0;
                fresh_next = 1'b0;
            end
            flags_next = {item_reg.data_byte[7:1], 1'b0};
            ref_next   = 2'd0;
            group_next = 8'd0;
            inner_next = 3'd0;
            if (item_reg.packet_last)
            begin
                main_v        = 1'b1;
                main_res.kind = KIND_SHORT;
                phase_next    = PH_DESC;
            end
            else if (item_reg.data_byte[FLAG_E] != item_reg.marker)
            begin
                main_v        = 1'b1;
                main_res.kind = KIND_MARKER;
                phase_next    = PH_SKIP;
            end
            else
            begin
                phase_next = next_from(3'd0, flags_next, 2'd0);
            end
        end
        else
        begin
            case (phase_reg)
                PH_PID1:
                begin
                    phase_next = item_reg.data_byte[7] ? PH_PID2
                                                       : next_from(3'd1, flags_reg, ref_reg);
                end
                PH_PID2:
                begin
                    phase_next = next_from(3'd1, flags_reg, ref_reg);
                end
                PH_LAYER:
                begin
                    ref_next   = flags_reg[FLAG_F] ? item_reg.data_byte[1:0] : 2'd0;
                    phase_next = next_from(3'd2, flags_reg, ref_next);
                end
                PH_REF, PH_REFX:
                begin
                    if (phase_reg == PH_REF && item_reg.data_byte[4])
                        phase_next = PH_REFX;
                    else
                    begin
                        ref_next   = ref_reg - 2'd1;
                        phase_next = (ref_next != 2'd0) ? PH_REF
                                                        : next_from(3'd3, flags_reg, ref_next);
                    end
                end
                PH_SS:
                begin
                    if (item_reg.data_byte[7:5] != 3'd0)
                    begin
                        // more than one spatial layer
                        main_v        = 1'b1;
                        main_res.kind = KIND_LAYERS;
                        phase_next    = item_reg.packet_last ? PH_DESC : PH_SKIP;
                        hdr           = 1'b0;
                    end
                    else
                    begin
                        if (item_reg.data_byte[3])
                            flags_next[FLAG_G] = 1'b1;
                        if (item_reg.data_byte[4])
                        begin
                            inner_next = 3'd4;
                            phase_next = PH_SSY;
                        end
                        else
                            phase_next = after_ssy(flags_next);
                    end
                end
                PH_SSY:
                begin
                    inner_next = inner_reg - 3'd1;
                    if (inner_next == 3'd0)
                        phase_next = after_ssy(flags_reg);
                end
                PH_SSG:
                begin
                    group_next = item_reg.data_byte;
                    phase_next = (item_reg.data_byte != 8'd0) ? PH_GROUP : PH_PAY0;
                end
                PH_GROUP:
                begin
                    if (item_reg.data_byte[3:2] != 2'd0)
                    begin
                        inner_next = {1'b0, item_reg.data_byte[3:2]};
                        phase_next = PH_PDIFF;
                    end
                    else
                    begin
                        group_next = group_reg - 8'd1;
                        phase_next = (group_next != 8'd0) ? PH_GROUP : PH_PAY0;
                    end
                end
                PH_PDIFF:
                begin
                    inner_next = inner_reg - 3'd1;
                    if (inner_next == 3'd0)
                    begin
                        group_next = group_reg - 8'd1;
                        phase_next = (group_next != 8'd0) ? PH_GROUP : PH_PAY0;
                    end
                end
                PH_PAY0, PH_PAY:
                begin
                    hdr = 1'b0;
                    if (phase_reg == PH_PAY0 && !open_reg && !flags_reg[FLAG_B])
                    begin
                        // no frame to join
                        main_v        = 1'b1;
                        main_res.kind = KIND_IGNORED;
                        phase_next    = item_reg.packet_last ? PH_DESC : PH_SKIP;
                    end
                    else
                    begin
                        if (phase_reg == PH_PAY0 && !open_reg)
                        begin
                            open_next  = 1'b1;
                            stamp_next = item_reg.rtp_timestamp;
                            fresh_next = 1'b1;
                        end
                        if (open_next)
                        begin
                            main_v                = 1'b1;
                            main_res.kind         = KIND_PAYLOAD;
                            main_res.payload_byte = item_reg.data_byte;
                            main_res.frame_first  = fresh_next;
                            main_res.frame_last   = item_reg.packet_last && flags_reg[FLAG_E];
                            main_res.frame_stamp  = stamp_next;
                            fresh_next            = 1'b0;
                            if (main_res.frame_last)
                                open_next = 1'b0;
                        end
                        phase_next = item_reg.packet_last ? PH_DESC : PH_PAY;
                    end
                end
                default:
                begin
                    hdr        = 1'b0;
                    phase_next = item_reg.packet_last ? PH_DESC : PH_SKIP;
                end
            endcase
            if (hdr && item_reg.packet_last)
            begin
                main_v        = 1'b1;
                main_res.kind = KIND_SHORT;
                phase_next    = PH_DESC;
            end
        end
    end

    always_comb
    begin
        disc_res             = '0;
        disc_res.kind        = KIND_DISCARD;
        disc_res.frame_stamp = stamp_reg;
        disc_res.run_last    = !main_v;

        push.r0    = disc ? disc_res : main_res;
        push.r1    = main_res;
        push.count = fire ? ({1'b0, disc} + {1'b0, main_v}) : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_DESC;
            flags_reg <= 8'd0;
            ref_reg   <= 2'd0;
            group_reg <= 8'd0;
            inner_reg <= 3'd0;
            open_reg  <= 1'b0;
            stamp_reg <= 32'd0;
            fresh_reg <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            flags_reg <= flags_next;
            ref_reg   <= ref_next;
            group_reg <= group_next;
            inner_reg <= inner_next;
            open_reg  <= open_next;
            stamp_reg <= stamp_next;
            fresh_reg <= fresh_next;
        end
    end

    `ASSERT_ALWAYS(a_push_count_range, push.count != 2'd3)
    `ASSERT_IMPLIES(a_push_needs_room, push.count != 2'd0, room)
    `ASSERT_IMPLIES(a_first_only_when_closed, main_v && main_res.kind == KIND_PAYLOAD && main_res.frame_first, !open_reg)

endmodule

`default_nettype wire

[rtl/vp9d_result_fifo.sv]
`default_nettype none

`include "assert_macros.svh"

module vp9d_result_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire vp9d_pkg::push_t push,
    output logic                room,
    vp9d_result_if.source       res
);
    import vp9d_pkg::*;

    result_t   mem_reg [FIFO_DEPTH];
    fifo_ptr_t wr_ptr_reg, wr_ptr_next;
    fifo_ptr_t rd_ptr_reg, rd_ptr_next;
    fifo_cnt_t count_reg, count_next;
    logic      pop;

    assign pop         = res.valid && res.ready;
    assign res.valid   = count_reg != '0;
    assign res.payload = mem_reg[rd_ptr_reg];
    assign room        = count_reg <= FIFO_ROOM_MAX;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + fifo_ptr_t'(push.count);
        rd_ptr_next = rd_ptr_reg + fifo_ptr_t'(pop);
        count_next  = count_reg + fifo_cnt_t'(push.count) - fifo_cnt_t'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem_reg[wr_ptr_reg] <= push.r0;
        if (push.count == 2'd2)
            mem_reg[wr_ptr_reg + fifo_ptr_t'(1)] <= push.r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `ASSERT_ALWAYS(a_count_bound, count_reg <= FIFO_FULL)
    `ASSERT_IMPLIES(a_no_overflow, push.count != 2'd0, count_reg <= FIFO_ROOM_MAX)
    `ASSERT_NEXT(a_empty_push_shows, count_reg == '0 && push.count != 2'd0, res.valid && res.payload == $past(push.r0))

endmodule

`default_nettype wire

[rtl/vp9_rtp_payload_depacketizer_core.sv]
`default_nettype none

// vp9 rtp payload depacketizer
// pkt: one rtp payload byte per request, tagged with packet first/last, the
//   rtp marker and the rtp timestamp; the descriptor byte leads each packet
// res: one result per request: a frame data byte with frame first/last marks
//   and frame timestamp, or a status (partial frame discarded, too short,
//   marker mismatch, unsupported layers, packet ignored); run_last flags the
//   final result caused by an input byte
// throughput: one input byte per cycle while the result queue has room; a
//   byte that yields two results (a discard followed by a descriptor status)
//   hands them to res one after the other
// path: an accepted byte waits in the input register for its parse step,
//   whose results go through the result queue to res
// reset: the frame closes, the parser waits for a descriptor, the result
//   queue empties; no clearing pass is needed
// stall: results collect in a four-entry queue; the input register holds its
//   byte and pkt.ready drops once the queue cannot take two more results
module vp9_rtp_payload_depacketizer_core (
    input  wire logic     clk,
    input  wire logic     rst_n,
    vp9d_byte_if.sink     pkt,
    vp9d_result_if.source res
);
    import vp9d_pkg::*;

    // parse step results headed into the queue
    push_t push;
    // queue can absorb a full step
    logic  room;

    // input register, parse state and the per-byte step logic
    vp9d_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .pkt   (pkt),
        .room  (room),
        .push  (push)
    );

    // result queue decoupling the receiver from the parser
    vp9d_result_fifo u_result_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .room  (room),
        .res   (res)
    );

endmodule

`default_nettype wire

[dv/vp9d_frame_check.sv]
`timescale 1ns / 1ps

module vp9d_frame_check (
    input  logic   clk,
    input  logic   rst_n,
    vp9d_byte_if   pkt,
    vp9d_result_if res,
    output int     fail_count,
    output int     pending
);
    import vp9d_pkg::*;

    // shadow copy of the depacketizer state
    logic        frame_open;
    logic [31:0] open_stamp;
    phase_t      phase;
    logic [7:0]  hdr_flags;
    logic [1:0]  refs_left;
    logic [7:0]  groups_left;
    logic [2:0]  inner_left;
    logic        fresh;

    result_t     step_results[$];
    result_t     results_due[$];
    int          errors;

    function automatic phase_t next_section(input int level);
        if (level < 1 && hdr_flags[FLAG_I]) return PH_PID1;
        if (level < 2 && hdr_flags[FLAG_L]) return PH_LAYER;
        if (level < 3 && refs_left != 2'd0) return PH_REF;
        if (level < 4 && hdr_flags[FLAG_V]) return PH_SS;
        return PH_PAY0;
    endfunction

    function automatic phase_t after_ss();
        return hdr_flags[FLAG_G] ? PH_SSG : PH_PAY0;
    endfunction

    function automatic phase_t group_step();
        groups_left = groups_left - 8'd1;
        return (groups_left != 8'd0) ? PH_GROUP : PH_PAY0;
    endfunction

    task automatic add_result(input kind_t k, input logic [7:0] b, input logic ff,
                              input logic fl, input logic [31:0] stamp);
        result_t r;
        r.kind         = k;
        r.payload_byte = b;
        r.frame_first  = ff;
        r.frame_last   = fl;
        r.frame_stamp  = stamp;
        r.run_last     = 1'b0;
        step_results.push_back(r);
    endtask

    task automatic parse_byte(input byte_item_t it);
        phase_t     ph;
        logic       in_header;
        logic       fl;
        logic [7:0] b;
        result_t    r;
        int         i;
        b = it.data_byte;
        ph = phase;
        in_header = 1'b1;
        step_results.delete();
        if (it.packet_first || ph == PH_DESC) begin
            // packet start: a timestamp change drops the partial frame
            if (frame_open && open_stamp != it.rtp_timestamp) begin
                add_result(KIND_DISCARD, 8'h00, 1'b0, 1'b0, open_stamp);
                frame_open = 1'b0;
                fresh = 1'b0;
            end
            hdr_flags = b & 8'hFE;
            refs_left = 2'd0;
            groups_left = 8'd0;
            inner_left = 3'd0;
            if (it.packet_last) begin
                add_result(KIND_SHORT, 8'h00, 1'b0, 1'b0, it.rtp_timestamp);
                ph = PH_DESC;
            end else if (b[FLAG_E] != it.marker) begin
                add_result(KIND_MARKER, 8'h00, 1'b0, 1'b0, it.rtp_timestamp);
                ph = PH_SKIP;
            end else begin
                ph = next_section(0);
            end
            in_header = 1'b0;
        end else begin
            case (ph)
                PH_PID1: ph = b[7] ? PH_PID2 : next_section(1);
                PH_PID2: ph = next_section(1);
                PH_LAYER:
                begin
                    refs_left = hdr_flags[FLAG_F] ? b[1:0] : 2'd0;
                    ph = next_section(2);
                end
                PH_REF, PH_REFX:
                begin
                    if (ph == PH_REF && b[4]) begin
                        ph = PH_REFX;
                    end else begin
                        refs_left = refs_left - 2'd1;
                        ph = (refs_left != 2'd0) ? PH_REF : next_section(3);
                    end
                end
                PH_SS:
                begin
                    if (b[7:5] != 3'd0) begin
                        add_result(KIND_LAYERS, 8'h00, 1'b0, 1'b0, it.rtp_timestamp);
                        ph = it.packet_last ? PH_DESC : PH_SKIP;
                        in_header = 1'b0;
                    end else begin
                        if (b[3]) hdr_flags[FLAG_G] = 1'b1;
                        if (b[4]) begin
                            inner_left = 3'd4;
                            ph = PH_SSY;
                        end else begin
                            ph = after_ss();
                        end
                    end
                end
                PH_SSY:
                begin
                    inner_left = inner_left - 3'd1;
                    if (inner_left == 3'd0) ph = after_ss();
                end
                PH_SSG:
                begin
                    groups_left = b;
                    ph = (b != 8'd0) ? PH_GROUP : PH_PAY0;
                end
                PH_GROUP:
                begin
                    if (b[3:2] != 2'd0) begin
                        inner_left = {1'b0, b[3:2]};
                        ph = PH_PDIFF;
                    end else begin
                        ph = group_step();
                    end
                end
                PH_PDIFF:
                begin
                    inner_left = inner_left - 3'd1;
                    if (inner_left == 3'd0) ph = group_step();
                end
                PH_PAY0, PH_PAY:
                begin
                    in_header = 1'b0;
                    if (ph == PH_PAY0 && !frame_open && !hdr_flags[FLAG_B]) begin
                        add_result(KIND_IGNORED, 8'h00, 1'b0, 1'b0, it.rtp_timestamp);
                        ph = it.packet_last ? PH_DESC : PH_SKIP;
                    end else begin
                        if (ph == PH_PAY0 && !frame_open) begin
                            frame_open = 1'b1;
                            open_stamp = it.rtp_timestamp;
                            fresh = 1'b1;
                        end
                        fl = it.packet_last && hdr_flags[FLAG_E];
                        if (frame_open) begin
                            add_result(KIND_PAYLOAD, b, fresh, fl, open_stamp);
                            fresh = 1'b0;
                            if (fl) frame_open = 1'b0;
                        end
                        ph = it.packet_last ? PH_DESC : PH_PAY;
                    end
                end
                default:
                begin
                    in_header = 1'b0;
                    ph = it.packet_last ? PH_DESC : PH_SKIP;
                end
            endcase
            if (in_header && it.packet_last) begin
                add_result(KIND_SHORT, 8'h00, 1'b0, 1'b0, it.rtp_timestamp);
                ph = PH_DESC;
            end
        end
        phase = ph;
        for (i = 0; i < step_results.size(); i++) begin
            r = step_results[i];
            r.run_last = (i == step_results.size() - 1);
            results_due.push_back(r);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        result_t got;
        result_t want;
        if (!rst_n) begin
            frame_open = 1'b0;
            open_stamp = '0;
            phase = PH_DESC;
            hdr_flags = '0;
            refs_left = '0;
            groups_left = '0;
            inner_left = '0;
            fresh = 1'b0;
            results_due.delete();
            errors = 0;
            fail_count <= 0;
            pending <= 0;
        end else begin
            if (pkt.valid && pkt.ready)
                parse_byte(pkt.payload);
            if (res.valid && res.ready) begin
                got = res.payload;
                if (results_due.size() == 0) begin
                    errors++;
                    $display("%0t: result mismatch, expected none, %s %0d byte %0h stamp %0h",
                             $time, "actual kind", got.kind, got.payload_byte,
                             got.frame_stamp);
                end else begin
                    want = results_due.pop_front();
                    check_field("kind", want.kind, got.kind);
                    check_field("payload_byte", want.payload_byte, got.payload_byte);
                    check_field("frame_first", want.frame_first, got.frame_first);
                    check_field("frame_last", want.frame_last, got.frame_last);
                    check_field("frame_stamp", want.frame_stamp, got.frame_stamp);
                    check_field("run_last", want.run_last, got.run_last);
                end
            end
            fail_count <= errors;
            pending <= results_due.size();
        end
    end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import vp9d_pkg::*;

    localparam int ITEM_COUNT = 600;
    localparam int CYCLE_LIMIT = 500000;

    // receiver behavior, re-chosen each time rx_left runs down to zero
    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_HOLD
    } rx_mode_t;

    logic        clk;
    logic        rst_n;
    int          fail_count;
    int          pending;
    int          cycles;
    int          burst_left;
    int          sent_items;
    logic [31:0] last_stamp;
    logic [7:0]  pkt_bytes[$];
    rx_mode_t    rx_mode;
    int          rx_left;

    vp9d_byte_if   pkt_if ();
    vp9d_result_if res_if ();

    vp9_rtp_payload_depacketizer_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pkt   (pkt_if),
        .res   (res_if)
    );

    // watches both channels, predicts every result and compares
    vp9d_frame_check u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .pkt        (pkt_if),
        .res        (res_if),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // watchdog: a hang anywhere ends the run as a failure
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result side backpressure: open, coin flip, mostly stalled, fully held
    always @(posedge clk) begin
        if (!rst_n) begin
            res_if.ready <= 1'b0;
            rx_mode <= RX_OPEN;
            rx_left <= 0;
        end else begin
            if (rx_left == 0) begin
                rx_mode <= rx_mode_t'($urandom_range(0, 3));
                rx_left <= $urandom_range(4, 48);
            end else begin
                rx_left <= rx_left - 1;
            end
            case (rx_mode)
                RX_OPEN:   res_if.ready <= 1'b1;
                RX_COIN:   res_if.ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: res_if.ready <= ($urandom_range(0, 3) == 0);
                default:   res_if.ready <= 1'b0;
            endcase
        end
    end

    // one request on pkt; bursts of back-to-back bytes separated by random gaps
    task automatic send_byte(input logic [7:0] data, input logic first, input logic last,
                             input logic mk, input logic [31:0] stamp);
        byte_item_t item;
        int         gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                pkt_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        item.data_byte = data;
        item.packet_first = first;
        item.packet_last = last;
        item.marker = mk;
        item.rtp_timestamp = stamp;
        pkt_if.valid <= 1'b1;
        pkt_if.payload <= item;
        @(posedge clk);
        while (!pkt_if.ready) @(posedge clk);
        burst_left--;
        sent_items++;
    endtask

    // stop sending until every predicted result has come out
    task automatic hold_until_drained();
        pkt_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        burst_left = 0;
    endtask

    // sends the first len bytes of pkt_bytes; without a last flag the packet is abandoned
    task automatic send_packet(input logic mk, input logic [31:0] stamp, input int len,
                               input logic with_last);
        int i;
        for (i = 0; i < len; i++)
            send_byte(pkt_bytes[i], i == 0, with_last && (i == len - 1), mk, stamp);
    endtask

    function automatic logic [31:0] pick_stamp();
        logic [31:0] s;
        int          r;
        r = $urandom_range(0, 7);
        if (r == 0) s = '0;
        else if (r == 1) s = '1;
        else if (r < 4) s = last_stamp;
        else s = $urandom;
        last_stamp = s;
        return s;
    endfunction

    // descriptor, the optional header sections it announces, then npay payload bytes
    task automatic build_packet(input logic [7:0] desc, input logic bad_layers, input int npay);
        logic [7:0] b;
        logic [7:0] g;
        int         nrefs;
        int         ngroups;
        int         i;
        pkt_bytes.delete();
        pkt_bytes.push_back(desc);
        nrefs = 0;
        if (desc[FLAG_I]) begin
            // picture id, a second byte when the extended flag is set
            b = 8'($urandom);
            pkt_bytes.push_back(b);
            if (b[7]) pkt_bytes.push_back(8'($urandom));
        end
        if (desc[FLAG_L]) begin
            b = 8'($urandom);
            pkt_bytes.push_back(b);
            if (desc[FLAG_F]) nrefs = b[1:0];
        end
        for (i = 0; i < nrefs; i++) begin
            b = 8'($urandom);
            pkt_bytes.push_back(b);
            if (b[4]) pkt_bytes.push_back(8'($urandom));
        end
        if (desc[FLAG_V]) begin
            b = 8'($urandom);
            if (!bad_layers) b[7:5] = 3'd0;
            else if (b[7:5] == 3'd0) b[7:5] = 3'($urandom_range(1, 7));
            pkt_bytes.push_back(b);
            if (b[7:5] == 3'd0) begin
                if (b[4]) repeat (4) pkt_bytes.push_back(8'($urandom));
                if (b[3]) begin
                    ngroups = $urandom_range(0, 3);
                    pkt_bytes.push_back(8'(ngroups));
                    for (i = 0; i < ngroups; i++) begin
                        g = 8'($urandom);
                        pkt_bytes.push_back(g);
                        repeat (g[3:2]) pkt_bytes.push_back(8'($urandom));
                    end
                end
            end
        end
        for (i = 0; i < npay; i++)
            pkt_bytes.push_back(8'($urandom));
    endtask

    // mostly well-formed frame: begin on the first packet, end and marker on the last
    task automatic send_frame();
        logic [31:0] stamp;
        logic [7:0]  desc;
        int          npk;
        int          k;
        stamp = pick_stamp();
        npk = $urandom_range(1, 3);
        for (k = 0; k < npk; k++) begin
            desc = 8'($urandom);
            desc[FLAG_B] = (k == 0);
            desc[FLAG_E] = (k == npk - 1);
            // now and then a stray begin bit or a timestamp jump mid-frame
            if ($urandom_range(0, 15) == 0) desc[FLAG_B] = ~desc[FLAG_B];
            if ($urandom_range(0, 15) == 0) stamp = pick_stamp();
            build_packet(desc, 1'b0, $urandom_range(1, 6));
            send_packet(desc[FLAG_E], stamp, pkt_bytes.size(), 1'b1);
        end
    endtask

    // possibly cut short, either ending early or just cut off by whatever comes next
    task automatic send_broken();
        logic [7:0]  desc;
        logic [31:0] stamp;
        int          len;
        desc = 8'($urandom);
        stamp = pick_stamp();
        build_packet(desc, 1'b0, $urandom_range(0, 4));
        len = $urandom_range(1, pkt_bytes.size());
        send_packet(desc[FLAG_E], stamp, len, 1'($urandom_range(0, 1)));
    endtask

    // complete packet with any descriptor, often a wrong marker or layered ss
    task automatic send_odd_packet();
        logic [7:0] desc;
        logic       mk;
        desc = 8'($urandom);
        mk = desc[FLAG_E] ^ ($urandom_range(0, 3) == 0);
        build_packet(desc, $urandom_range(0, 2) == 0, $urandom_range(0, 4));
        send_packet(mk, pick_stamp(), pkt_bytes.size(), 1'b1);
    endtask

    // loose bytes with random flags
    task automatic send_noise();
        int n;
        int i;
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++)
            send_byte(8'($urandom), $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
                      1'($urandom_range(0, 1)),
                      $urandom_range(0, 1) ? last_stamp : 32'($urandom));
    endtask

    initial begin : stimulus
        int sel;
        rst_n <= 1'b0;
        pkt_if.valid <= 1'b0;
        pkt_if.payload <= '0;
        burst_left = 0;
        sent_items = 0;
        last_stamp = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // descriptor alone is too short
        pkt_bytes = '{8'hFF};
        send_packet(1'b1, 32'h0000_0000, pkt_bytes.size(), 1'b1);
        // end bit set but marker clear
        pkt_bytes = '{8'h0C, 8'h55};
        send_packet(1'b0, 32'h0000_0000, pkt_bytes.size(), 1'b1);
        // no frame open and no begin bit: ignored
        pkt_bytes = '{8'h00, 8'hAA};
        send_packet(1'b0, 32'h0000_0000, pkt_bytes.size(), 1'b1);
        // scalability structure with several layers
        pkt_bytes = '{8'h02, 8'hE0, 8'h11};
        send_packet(1'b0, 32'h0000_0000, pkt_bytes.size(), 1'b1);
        // opens a frame at the top timestamp, left unfinished
        pkt_bytes = '{8'h08, 8'h00};
        send_packet(1'b0, 32'hFFFF_FFFF, pkt_bytes.size(), 1'b1);
        // new timestamp drops it; every header section present, frame in one packet
        pkt_bytes = '{8'hBE, 8'hFF, 8'h7F, 8'h02, 8'h10, 8'h33, 8'h00, 8'h18,
                      8'hA1, 8'hA2, 8'hA3, 8'hA4, 8'h01, 8'h04, 8'h5A, 8'hFF};
        send_packet(1'b1, 32'h0000_0000, pkt_bytes.size(), 1'b1);
        // ends inside the extended picture id
        pkt_bytes = '{8'h80, 8'h80};
        send_packet(1'b0, 32'h1234_5678, pkt_bytes.size(), 1'b1);

        hold_until_drained();

        while (sent_items < ITEM_COUNT) begin
            sel = $urandom_range(0, 99);
            if (sel < 65) send_frame();
            else if (sel < 75) send_broken();
            else if (sel < 85) send_noise();
            else if (sel < 97) send_odd_packet();
            else hold_until_drained();
        end

        pkt_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (16) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
